/* hdl/plst_pkg.sv */
// ============================================================================
// plst_pkg
// Shared types and constants of the positional list store.
// ============================================================================
`default_nettype none

package plst_pkg;

    // Number of entries the store holds.
    localparam int CAPACITY = 16;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Fixed field widths of the transactions.
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int ST_W    = 2;
    localparam int LEN_W   = 5;

    // Width that holds both a position and a count plus one.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DUMP      = 3'd6
    } plst_op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } plst_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_VAL,
        S_SHIFT_DN,
        S_DUMP_RD,
        S_DUMP_WAIT,
        S_RESP
    } plst_state_t;

    typedef struct packed {
        logic [OP_W-1:0]           req_type;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } plst_req_t;

    typedef struct packed {
        logic [ST_W-1:0]           status;
        logic signed [VALUE_W-1:0] element;
        logic [LEN_W-1:0]          length;
        logic                      last;
    } plst_rsp_t;

endpackage

`default_nettype wire

/* hdl/plst_ram.sv */
// ============================================================================
// plst_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/positional_list_store.sv */
// ============================================================================
// positional_list_store
// Ordered sequence of signed values in a RAM with insert, delete and dump.
// ============================================================================
//
// Channel  Direction  Handshake          Payload
// s_       input      s_valid / s_ready  plst_req_t (req_type, value, position)
// m_       output     m_valid / m_ready  plst_rsp_t (status, element, length, last)
//
// One request transaction is taken at a time, only while the sequencer is idle.
// An insert shifts the entries from slot i up, top first, then writes the value;
// a delete shifts the entries above slot i down; rejected requests go straight
// to the response. The shift loop moves one entry per cycle through the single
// write port of the entry RAM. A dump does one RAM read then one output load per entry.
// Reset clears the count and the control state; the RAM needs no clearing.
// A stalled output register holds back only the next result; the next request
// is taken while the previous response still waits.
//
`default_nettype none

module positional_list_store
    import plst_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire plst_req_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output plst_rsp_t      m_data
);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    plst_state_t         state_reg,     state_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [CNT_W-1:0]    ptr_reg,       ptr_next;
    logic [CNT_W-1:0]    idx_reg,       idx_next;
    plst_status_t        st_reg,        st_next;
    logic [VALUE_W-1:0]  val_reg,       val_next;
    logic                pend_reg,      pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                m_valid_reg,   m_valid_next;
    plst_rsp_t           m_data_reg,    m_data_next;

    // RAM port signals.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    // ------------------------------------------------------------------------
    // Request decode. All checks use the count before the request.
    // ------------------------------------------------------------------------
    plst_state_t         dec_state;
    plst_status_t        dec_st;
    logic [CNT_W-1:0]    dec_idx;
    logic [CNT_W-1:0]    dec_count;

    logic                accept;
    logic                out_free;
    logic                is_empty;
    logic                is_full;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CNT_W-1:0]    pos_idx;
    logic [CNT_W-1:0]    ptr_dec;
    logic [CNT_W-1:0]    ptr_inc;
    logic                dump_last;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext  = CMP_W'(s_data.position);
    assign cnt_ext  = CMP_W'(count_reg);
    // Only meaningful once the position has passed its range check.
    assign pos_idx  = CNT_W'(pos_ext - CMP_W'(1));
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign dump_last = (ptr_inc == count_reg);

    always_comb begin
        dec_state = S_RESP;
        dec_st    = ST_OK;
        dec_idx   = '0;
        dec_count = count_reg;
        unique case (s_data.req_type)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                if (s_data.req_type == OP_INS_FIRST) begin
                    dec_idx = '0;
                end else if (s_data.req_type == OP_INS_LAST) begin
                    dec_idx = count_reg;
                end else begin
                    dec_idx = pos_idx;
                end
                // The position check comes ahead of the full check.
                if (s_data.req_type == OP_INS_AT &&
                    (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
                    dec_st = ST_BADPOS;
                end else if (is_full) begin
                    dec_st = ST_FULL;
                end else begin
                    dec_state = S_SHIFT_UP;
                    dec_count = count_reg + CNT_W'(1);
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                if (s_data.req_type == OP_DEL_FIRST) begin
                    dec_idx = '0;
                end else if (s_data.req_type == OP_DEL_LAST) begin
                    dec_idx = count_reg - CNT_W'(1);
                end else begin
                    dec_idx = pos_idx;
                end
                // The empty check comes ahead of the position check.
                if (is_empty) begin
                    dec_st = ST_EMPTY;
                end else if (s_data.req_type == OP_DEL_AT &&
                             (pos_ext == '0 || pos_ext > cnt_ext)) begin
                    dec_st = ST_BADPOS;
                end else begin
                    dec_state = S_SHIFT_DN;
                    dec_count = count_reg - CNT_W'(1);
                end
            end
            OP_DUMP: begin
                if (is_empty) begin
                    dec_st = ST_EMPTY;
                end else begin
                    dec_state = S_DUMP_RD;
                end
            end
            default: begin
                // Unused request code: plain response with the count.
                dec_st = ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = dec_state;
                end
            end
            S_SHIFT_UP: begin
                if (ptr_reg == idx_reg) begin
                    state_next = S_INS_VAL;
                end
            end
            S_INS_VAL: begin
                state_next = S_RESP;
            end
            S_SHIFT_DN: begin
                // count_reg already holds the reduced count here.
                if (ptr_reg >= count_reg) begin
                    state_next = S_RESP;
                end
            end
            S_DUMP_RD: begin
                if (out_free) begin
                    state_next = S_DUMP_WAIT;
                end
            end
            S_DUMP_WAIT: begin
                state_next = dump_last ? S_IDLE : S_DUMP_RD;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs, RAM control and datapath
    // ------------------------------------------------------------------------
    always_comb begin
        s_ready        = (state_reg == S_IDLE);
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        st_next        = st_reg;
        val_next       = val_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        // A read issued last cycle is written back one slot away this cycle.
        ram_we    = pend_reg;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    count_next = dec_count;
                    st_next    = dec_st;
                    idx_next   = dec_idx;
                    val_next   = s_data.value;
                    // Inserts shift from the top down, deletes and dumps go up.
                    ptr_next   = (dec_state == S_SHIFT_UP) ? count_reg : dec_idx;
                    if (dec_state == S_DUMP_RD) begin
                        ptr_next = '0;
                    end
                end
            end
            S_SHIFT_UP: begin
                if (ptr_reg != idx_reg) begin
                    ram_re         = 1'b1;
                    ram_raddr      = ptr_dec[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next       = ptr_dec;
                end
            end
            S_INS_VAL: begin
                // The shift has drained, so the write port is free.
                ram_we    = 1'b1;
                ram_waddr = idx_reg[ADDR_W-1:0];
                ram_wdata = val_reg;
            end
            S_SHIFT_DN: begin
                if (ptr_reg < count_reg) begin
                    ram_re         = 1'b1;
                    ram_raddr      = ptr_inc[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next       = ptr_inc;
                end
            end
            S_DUMP_RD: begin
                if (out_free) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[ADDR_W-1:0];
                end
            end
            S_DUMP_WAIT: begin
                // The output register was emptied when the read was issued.
                m_valid_next        = 1'b1;
                m_data_next.status  = ST_OK;
                m_data_next.element = ram_rdata;
                m_data_next.length  = LEN_W'(count_reg);
                m_data_next.last    = dump_last;
                ptr_next            = ptr_inc;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_data_next.status  = st_reg;
                    m_data_next.element = '0;
                    m_data_next.length  = LEN_W'(count_reg);
                    m_data_next.last    = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase

        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    // ------------------------------------------------------------------------
    // Entry RAM
    // ------------------------------------------------------------------------
    plst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        idx_reg       <= idx_next;
        st_reg        <= st_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        m_data_reg    <= m_data_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The count never goes past the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // A new request never arrives while a shift write-back is still in flight.
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !pend_reg)
        else $error("request taken during a pending write-back");

    // Shift reads and write-backs never touch the same entry in one cycle.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write collide");

    // Only dump results may be non-final, and those always carry status ok.
    a_nonlast_is_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (m_data.status == ST_OK))
        else $error("non-final result with bad status");

    // A loaded dump result follows a dump read issued in the cycle before.
    a_dump_read_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP_WAIT) |-> $past(ram_re))
        else $error("dump result without RAM read");

endmodule

`default_nettype wire
